@@ hw/rtl/imx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imx_pkg
// Shared types, constants and helpers of the integer matrix engine.
// ----------------------------------------------------------------------------
package imx_pkg;

  localparam int MAX_DIM  = 8;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int DIM_W    = 4;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR = 3'd4;

  // operation modes
  localparam logic [2:0] MODE_MUL   = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_SUB   = 3'd2;
  localparam logic [2:0] MODE_ADDS  = 3'd3;
  localparam logic [2:0] MODE_SUBS  = 3'd4;
  localparam logic [2:0] MODE_MULS  = 3'd5;

  // effective configuration seen by the datapath and sequencer
  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols_a;
    logic [DIM_W-1:0]  cols_b;
    logic [2:0]        mode;
    logic [DATA_W-1:0] scalar;
  } cfg_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic              op_en;
    logic              acc_en;
    logic              acc_first;
  } dp_ctl_t;

  // zero acts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

@@ hw/rtl/imx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imx_if
// Valid/ready channels of the matrix engine: element input, result output.
// ----------------------------------------------------------------------------
interface imx_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface imx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         result_row;
  logic [2:0]         result_col;
  logic               last;

  modport source (output valid, output result_value, output result_row,
                  output result_col, output last, input ready);
  modport sink   (input valid, input result_value, input result_row,
                  input result_col, input last, output ready);
endinterface

@@ hw/rtl/imx_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imx_seq
// Load counters and result sequencer: walks rows, columns and the inner
// product index, driving the shared arithmetic unit one step at a time.
// ----------------------------------------------------------------------------
module imx_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  imx_pkg::cfg_t               cfg,
  input  logic                        cfg_hit,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [imx_pkg::IDX_W-1:0]   out_row,
  output logic [imx_pkg::IDX_W-1:0]   out_col,
  output logic                        out_last,
  output imx_pkg::dp_ctl_t            ctl
);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RD   = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                           state;
  logic [imx_pkg::CNT_W-1:0]        load_count;
  logic                             loading_b;
  logic [imx_pkg::IDX_W-1:0]        i, j, k;
  logic [imx_pkg::ADDR_W-1:0]       row_base;
  logic [imx_pkg::ADDR_W-1:0]       b_idx;

  logic                             is_mul, loads_b, accept, done_load;
  logic                             k_last, j_last, i_last;
  logic [imx_pkg::CNT_W-1:0]        area_a, need_b;
  logic [2*imx_pkg::DIM_W-1:0]      prod_ra, prod_ab;
  logic [imx_pkg::DIM_W-1:0]        res_cols;

  always_comb begin
    is_mul   = (cfg.mode == imx_pkg::MODE_MUL);
    loads_b  = (cfg.mode == imx_pkg::MODE_MUL) || (cfg.mode == imx_pkg::MODE_ADD) ||
               (cfg.mode == imx_pkg::MODE_SUB);
    prod_ra  = cfg.rows * cfg.cols_a;
    prod_ab  = cfg.cols_a * cfg.cols_b;
    area_a   = prod_ra[imx_pkg::CNT_W-1:0];
    need_b   = is_mul ? prod_ab[imx_pkg::CNT_W-1:0] : area_a;
    res_cols = is_mul ? cfg.cols_b : cfg.cols_a;
    in_ready = (state == S_LOAD);
    accept   = in_valid && in_ready;
    done_load = ((load_count + imx_pkg::CNT_W'(1)) == (loading_b ? need_b : area_a));
    k_last   = !is_mul || (({1'b0, k} + imx_pkg::DIM_W'(1)) == cfg.cols_a);
    j_last   = (({1'b0, j} + imx_pkg::DIM_W'(1)) == res_cols);
    i_last   = (({1'b0, i} + imx_pkg::DIM_W'(1)) == cfg.rows);

    out_valid = (state == S_OUT);
    out_row   = i;
    out_col   = j;
    out_last  = i_last && j_last;

    ctl.we_a      = accept && !loading_b;
    ctl.we_b      = accept && loading_b;
    ctl.waddr     = load_count[imx_pkg::ADDR_W-1:0];
    ctl.rd_en     = (state == S_RD);
    ctl.raddr_a   = row_base + imx_pkg::ADDR_W'(is_mul ? k : j);
    ctl.raddr_b   = is_mul ? b_idx : row_base + imx_pkg::ADDR_W'(j);
    ctl.op_en     = (state == S_MUL);
    ctl.acc_en    = (state == S_ACC);
    ctl.acc_first = (k == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      loading_b  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_hit) begin
            // a write to registers 0 to 4 abandons a partial load
            load_count <= '0;
            loading_b  <= 1'b0;
          end else if (accept) begin
            if (done_load) begin
              load_count <= '0;
              if (!loading_b && loads_b) begin
                loading_b <= 1'b1;
              end else begin
                loading_b <= 1'b0;
                state     <= S_RD;
                i         <= '0;
                j         <= '0;
                k         <= '0;
                row_base  <= '0;
                b_idx     <= '0;
              end
            end else begin
              load_count <= load_count + imx_pkg::CNT_W'(1);
            end
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (k_last) begin
            state <= S_OUT;
          end else begin
            k     <= k + imx_pkg::IDX_W'(1);
            b_idx <= b_idx + imx_pkg::ADDR_W'(cfg.cols_b);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            k <= '0;
            if (j_last) begin
              if (i_last) begin
                state <= S_LOAD;
              end else begin
                i        <= i + imx_pkg::IDX_W'(1);
                j        <= '0;
                row_base <= row_base + imx_pkg::ADDR_W'(cfg.cols_a);
                b_idx    <= '0;
                state    <= S_RD;
              end
            end else begin
              j     <= j + imx_pkg::IDX_W'(1);
              b_idx <= imx_pkg::ADDR_W'(j) + imx_pkg::ADDR_W'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

@@ hw/rtl/imx_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imx_dp
// Element stores for A and B, one shared multiply/add/subtract unit and the
// accumulator that holds the current result word.
// ----------------------------------------------------------------------------
module imx_dp (
  input  logic                        clk,
  input  imx_pkg::cfg_t               cfg,
  input  imx_pkg::dp_ctl_t            ctl,
  input  logic [imx_pkg::DATA_W-1:0]  element,
  output logic [imx_pkg::DATA_W-1:0]  result
);

  logic [imx_pkg::DATA_W-1:0] mem_a [imx_pkg::DEPTH];
  logic [imx_pkg::DATA_W-1:0] mem_b [imx_pkg::DEPTH];
  logic [imx_pkg::DATA_W-1:0] rd_a, rd_b;
  logic [imx_pkg::DATA_W-1:0] opnd, unit_out, prod, acc;

  always_ff @(posedge clk) begin
    if (ctl.we_a) mem_a[ctl.waddr] <= element;
    if (ctl.we_b) mem_b[ctl.waddr] <= element;
    if (ctl.rd_en) begin
      rd_a <= mem_a[ctl.raddr_a];
      rd_b <= mem_b[ctl.raddr_b];
    end
  end

  // shared unit; matrix modes take B, scalar modes the scalar
  always_comb begin
    if (cfg.mode == imx_pkg::MODE_MUL || cfg.mode == imx_pkg::MODE_ADD ||
        cfg.mode == imx_pkg::MODE_SUB) begin
      opnd = rd_b;
    end else begin
      opnd = cfg.scalar;
    end
    unique case (cfg.mode)
      imx_pkg::MODE_MUL,
      imx_pkg::MODE_MULS: unit_out = rd_a * opnd;
      imx_pkg::MODE_ADD,
      imx_pkg::MODE_ADDS: unit_out = rd_a + opnd;
      imx_pkg::MODE_SUB,
      imx_pkg::MODE_SUBS: unit_out = rd_a - opnd;
      default:            unit_out = rd_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op_en) prod <= unit_out;
    if (ctl.acc_en) acc <= ctl.acc_first ? prod : acc + prod;
  end

  assign result = acc;

endmodule

@@ hw/rtl/integer_matrix_arithmetic_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_arithmetic_top
// Signed 32-bit matrix engine: multiply, elementwise add/subtract, scalar ops.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while loading (A, then B in the matrix
// modes); the word that completes the load starts the result pass, during
// which no input is taken. Every result step runs through the store read
// port, the one shared multiply/add unit and the accumulator (S_RD, S_MUL,
// S_ACC) once per product, and each result word then waits in S_OUT for the
// output to take it. Rows, column counts of 0 act as 1 and values above 8 as
// 8; any write to registers 0 to 4 drops a partially loaded matrix.
module integer_matrix_arithmetic_top (
  input  logic                            clk,
  input  logic                            rst,
  imx_in_if.sink                          in_ch,
  imx_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [imx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imx_pkg::DATA_W-1:0]      cfg_data
);

  logic [imx_pkg::DIM_W-1:0]  rows_a, cols_a, cols_b;
  logic [2:0]                 mode;
  logic [imx_pkg::DATA_W-1:0] scalar;
  logic                       cfg_hit;
  imx_pkg::cfg_t              cfg;
  imx_pkg::dp_ctl_t           ctl;
  logic [imx_pkg::DATA_W-1:0] result;

  assign cfg_hit = cfg_we && (cfg_index <= imx_pkg::REG_SCALAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= imx_pkg::DIM_W'(1);
      cols_a <= imx_pkg::DIM_W'(1);
      cols_b <= imx_pkg::DIM_W'(1);
      mode   <= imx_pkg::MODE_MUL;
      scalar <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imx_pkg::REG_ROWS_A: rows_a <= cfg_data[imx_pkg::DIM_W-1:0];
        imx_pkg::REG_COLS_A: cols_a <= cfg_data[imx_pkg::DIM_W-1:0];
        imx_pkg::REG_COLS_B: cols_b <= cfg_data[imx_pkg::DIM_W-1:0];
        imx_pkg::REG_MODE:   mode   <= cfg_data[2:0];
        imx_pkg::REG_SCALAR: scalar <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rows   = imx_pkg::eff_dim(rows_a);
    cfg.cols_a = imx_pkg::eff_dim(cols_a);
    cfg.cols_b = imx_pkg::eff_dim(cols_b);
    cfg.mode   = mode;
    cfg.scalar = scalar;
  end

  imx_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_hit   (cfg_hit),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_row   (out_ch.result_row),
    .out_col   (out_ch.result_col),
    .out_last  (out_ch.last),
    .ctl       (ctl)
  );

  imx_dp u_dp (
    .clk     (clk),
    .cfg     (cfg),
    .ctl     (ctl),
    .element (in_ch.element),
    .result  (result)
  );

  assign out_ch.result_value = result;

endmodule

@@ hw/rtl/imx_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imx_chk
// Port-level checks of the matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
module imx_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic        last
);

  // results only come out while input is held off
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result word is shown");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(last))
    else $error("stalled result word changed");

  // the pass continues until the flagged word is taken
  a_mid_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("input reopened before the last result word");

  a_end_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("engine did not return to loading after the last word");

endmodule

bind integer_matrix_arithmetic_top imx_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .last         (out_ch.last)
);

@@ tb/integer_matrix_arithmetic_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_arithmetic_top_test
// Self-checking bench for the integer matrix engine. Elements stream in over
// the input channel. A local copy of the engine state predicts every result
// word when the word that completes a load is taken. Output words are matched
// in order against that prediction. Registers change only between phases,
// once the engine has drained. Random gaps are applied on both channels.
// ----------------------------------------------------------------------------
module integer_matrix_arithmetic_top_test;
  import imx_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 230;

  // unused register indexes and the mode codes that just pass A through
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [2:0]           MODE_RSVD6  = 3'd6;
  localparam logic [2:0]           MODE_RSVD7  = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } result_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  imx_in_if  in_ch ();
  imx_out_if out_ch ();

  integer_matrix_arithmetic_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // engine copy used for prediction
  logic [3:0]  rows_cfg;
  logic [3:0]  cols_a_cfg;
  logic [3:0]  cols_b_cfg;
  logic [2:0]  mode_cfg;
  logic [31:0] scalar_cfg;
  logic [31:0] mat_a [DEPTH];
  logic [31:0] mat_b [DEPTH];
  int unsigned fill;
  bit          filling_b;

  logic [31:0]  element_queue [$];
  result_word_t due_results [$];

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          drain_hold;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned dim_eff(input logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (quiet || sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      case ($urandom_range(0, 4))
        0: w = 32'h8000_0000;
        1: w = 32'h7fff_ffff;
        2: w = 32'h0000_0000;
        3: w = 32'hffff_ffff;
        default: w = 32'h0000_0001;
      endcase
    end else if (sel < 8) begin
      w = 32'($urandom_range(0, 16)) - 32'd8;
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  function automatic logic [3:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 4'($urandom_range(1, 3));
    if (sel < 88) return 4'd0;
    if (sel < 95) return 4'($urandom_range(4, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 6) return MODE_MUL;
    if (sel < 9) return MODE_ADD;
    if (sel < 12) return MODE_SUB;
    if (sel < 14) return MODE_ADDS;
    if (sel < 16) return MODE_SUBS;
    if (sel < 18) return MODE_MULS;
    if (sel < 19) return MODE_RSVD6;
    return MODE_RSVD7;
  endfunction

  // elements in one complete load under the current settings
  function automatic int unsigned load_size();
    int unsigned r, ca, cb, n;
    r  = dim_eff(rows_cfg);
    ca = dim_eff(cols_a_cfg);
    cb = dim_eff(cols_b_cfg);
    n  = r * ca;
    if (mode_cfg == MODE_MUL) n += ca * cb;
    else if (mode_cfg == MODE_ADD || mode_cfg == MODE_SUB) n += r * ca;
    return n;
  endfunction

  task automatic produce_matrix(input int unsigned r, input int unsigned c);
    int unsigned  ca;
    logic [31:0]  a;
    logic [31:0]  acc;
    result_word_t w;
    ca = dim_eff(cols_a_cfg);
    for (int unsigned i = 0; i < r; i++) begin
      for (int unsigned j = 0; j < c; j++) begin
        a = mat_a[(i * ca + j) % DEPTH];
        case (mode_cfg)
          MODE_MUL: begin
            acc = '0;
            for (int unsigned k = 0; k < ca; k++)
              acc = acc + mat_a[(i * ca + k) % DEPTH] * mat_b[(k * c + j) % DEPTH];
          end
          MODE_ADD:  acc = a + mat_b[(i * ca + j) % DEPTH];
          MODE_SUB:  acc = a - mat_b[(i * ca + j) % DEPTH];
          MODE_ADDS: acc = a + scalar_cfg;
          MODE_SUBS: acc = a - scalar_cfg;
          MODE_MULS: acc = a * scalar_cfg;
          default:   acc = a;
        endcase
        w.value = acc;
        w.row   = 3'(i);
        w.col   = 3'(j);
        w.last  = (i + 1 == r) && (j + 1 == c);
        due_results.push_back(w);
      end
    end
  endtask

  task automatic absorb_element(input logic [31:0] e);
    int unsigned r, ca, cb, need;
    r  = dim_eff(rows_cfg);
    ca = dim_eff(cols_a_cfg);
    cb = dim_eff(cols_b_cfg);
    if (!filling_b) begin
      mat_a[fill % DEPTH] = e;
      fill++;
      if (fill >= r * ca) begin
        fill = 0;
        if (mode_cfg <= MODE_SUB) filling_b = 1'b1;
        else produce_matrix(r, ca);
      end
    end else begin
      need = (mode_cfg == MODE_MUL) ? ca * cb : r * ca;
      mat_b[fill % DEPTH] = e;
      fill++;
      if (fill >= need) begin
        fill = 0;
        filling_b = 1'b0;
        produce_matrix(r, (mode_cfg == MODE_MUL) ? cb : ca);
      end
    end
  endtask

  // write enable stays high across back-to-back writes; close_writes drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ROWS_A: rows_cfg   = data[3:0];
      REG_COLS_A: cols_a_cfg = data[3:0];
      REG_COLS_B: cols_b_cfg = data[3:0];
      REG_MODE:   mode_cfg   = data[2:0];
      REG_SCALAR: scalar_cfg = data;
      default: ;
    endcase
    if (idx <= REG_SCALAR) begin
      fill = 0;
      filling_b = 1'b0;
    end
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [3:0] rows, input logic [3:0] cols,
                              input logic [3:0] cols_b, input logic [2:0] mode,
                              input logic [31:0] scl);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(REG_ROWS_A, {junk[27:0], rows});
    write_reg(REG_COLS_A, {junk[27:0], cols});
    write_reg(REG_COLS_B, {junk[27:0], cols_b});
    write_reg(REG_MODE, {junk[28:0], mode});
    write_reg(REG_SCALAR, scl);
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_5, $urandom);
    close_writes();
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) element_queue.push_back(rand_word());
  endtask

  // sampled on the falling edge so all clocked updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (element_queue.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // element driver
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.element <= '0;
      send_gap   = 0;
      drain_hold = 1'b0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        absorb_element(in_ch.element);
        nxt_valid = 1'b0;
        send_gap  = pick_gap();
        if ($urandom_range(0, 49) == 0) drain_hold = 1'b1;
      end
      if (drain_hold && due_results.size() == 0) drain_hold = 1'b0;
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!drain_hold && element_queue.size() != 0) begin
          in_ch.element <= element_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_word_t want;
    result_word_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_value, out_ch.result_row, out_ch.result_col, out_ch.last};
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected: value %h row %0d col %0d last %0b",
                   $time, got.value, got.row, got.col, got.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected value %h row %0d col %0d last %0b, got value %h row %0d col %0d last %0b",
                     $time, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
            errors++;
          end
        end
        if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 15) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_matrix_arithmetic_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned per_load, loads, k, phase, random_items;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.element = '0;
    out_ch.ready  = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    quiet         = 1'b0;
    rows_cfg      = 4'd1;
    cols_a_cfg    = 4'd1;
    cols_b_cfg    = 4'd1;
    mode_cfg      = MODE_MUL;
    scalar_cfg    = '0;
    fill          = 0;
    filling_b     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1x1 multiply, most negative squared wraps to zero
    element_queue.push_back(32'h8000_0000);
    element_queue.push_back(32'h8000_0000);

    wait_idle();
    program_regs(4'd0, 4'd2, 4'd1, MODE_ADD, 32'd0);
    element_queue.push_back(32'h7fff_ffff);
    element_queue.push_back(32'h8000_0000);
    element_queue.push_back(32'h0000_0001);
    element_queue.push_back(32'hffff_ffff);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_SUB, 32'd0);
    element_queue.push_back(32'h8000_0000);
    element_queue.push_back(32'h0000_0001);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_ADDS, 32'h7fff_ffff);
    element_queue.push_back(32'h0000_0001);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_SUBS, 32'h8000_0000);
    element_queue.push_back(32'h0000_0000);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_MULS, 32'hffff_ffff);
    element_queue.push_back(32'h8000_0000);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_RSVD6, $urandom);
    push_random(1);

    wait_idle();
    program_regs(4'd1, 4'd1, 4'd1, MODE_RSVD7, $urandom);
    element_queue.push_back(32'hffff_ffff);

    // a write to any defined register drops a half-loaded matrix
    wait_idle();
    program_regs(4'd1, 4'd2, 4'd1, MODE_MUL, 32'd0);
    push_random(1);
    wait_idle();
    write_reg(REG_COLS_A, 32'd2);
    close_writes();
    push_random(4);

    // writes to unused indexes leave the load intact
    wait_idle();
    program_regs(4'd1, 4'd2, 4'd1, MODE_ADDS, 32'd5);
    push_random(1);
    wait_idle();
    write_reg(REG_SPARE_5, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    close_writes();
    push_random(1);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      // first two phases hit the largest result and the longest dot product
      if (phase == 0) program_regs(4'd15, 4'd1, 4'd9, MODE_MUL, rand_word());
      else if (phase == 1) program_regs(4'd1, 4'd12, 4'd1, MODE_MUL, rand_word());
      else program_regs(pick_dim(), pick_dim(), pick_dim(), pick_mode(), rand_word());
      per_load = load_size();
      loads = (per_load > 24) ? 1 : $urandom_range(1, 3);
      repeat (loads) begin
        push_random(per_load);
        random_items += per_load;
      end
      // broken load, dropped by the next phase's register writes
      if (per_load > 1 && $urandom_range(0, 6) == 0) begin
        k = $urandom_range(1, per_load - 1);
        push_random(k);
        random_items += k;
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) $display("integer_matrix_arithmetic_top_test: PASS");
    else $display("integer_matrix_arithmetic_top_test: FAIL");
    $finish;
  end

endmodule
